// ===== sv/blgr_pkg.sv =====
// Shared types, constants and helper functions of the bitmap glyph row renderer.
// No dependencies; every other file of the block imports this package.
package blgr_pkg;

   // Glyph geometry limits and fixed values.
   localparam int unsigned MASK_COLS      = 32;
   localparam int unsigned MAX_GLYPH_COLS = 32;
   localparam int unsigned MAX_GLYPH_ROWS = 32;
   localparam int unsigned COLS_LIMIT =
      (MAX_GLYPH_COLS < MASK_COLS) ? MAX_GLYPH_COLS : MASK_COLS;
   localparam int unsigned ROWS_LIMIT =
      (MAX_GLYPH_ROWS < 32) ? MAX_GLYPH_ROWS : 32;
   localparam logic [7:0]  FALLBACK_GLYPH = 8'd63;  // the '?' character
   localparam int unsigned CURSOR_W       = 17;

   // Register indexes of the configuration port.
   typedef enum logic [2:0] {
      REG_FONT_READY  = 3'd0,
      REG_GLYPH_TOTAL = 3'd1,
      REG_GLYPH_BYTES = 3'd2,
      REG_GLYPH_COLS  = 3'd3,
      REG_GLYPH_ROWS  = 3'd4
   } csr_reg_type;

   // Request kinds.
   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_DRAW = 1'b1
   } kind_type;

   typedef struct packed {
      logic        font_ready;
      logic [12:0] glyph_total;
      logic [7:0]  glyph_bytes;
      logic [5:0]  glyph_cols;
      logic [5:0]  glyph_rows;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [13:0] font_addr;
      logic [7:0]  font_byte;
      logic [7:0]  code;
      logic        start_text;
      logic [15:0] start_x;
      logic [15:0] pos_y;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } req_type;

   // One classified request as it waits between front and back.
   typedef struct packed {
      kind_type              kind;
      logic [13:0]           font_addr;
      logic [7:0]            font_byte;
      logic [7:0]            glyph;
      logic [CURSOR_W-1:0]   row_x;
      logic [15:0]           pos_y;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
   } item_type;

   typedef struct packed {
      logic [CURSOR_W-1:0] row_x;
      logic [CURSOR_W-1:0] row_y;
      logic [31:0]         pixel_mask;
      logic [7:0]          red;
      logic [7:0]          green;
      logic [7:0]          blue;
      logic                last_row;
   } result_type;

   // Width actually used for masks, bytes per row and cursor advance.
   function automatic logic [5:0] eff_cols(input logic [5:0] cols);
      if (cols > 6'(COLS_LIMIT)) begin
         return 6'(COLS_LIMIT);
      end
      return cols;
   endfunction

   // Row count actually drawn.
   function automatic logic [5:0] eff_rows(input logic [5:0] rows);
      if (rows > 6'(ROWS_LIMIT)) begin
         return 6'(ROWS_LIMIT);
      end
      return rows;
   endfunction

   // Store bytes per glyph row: the width rounded up to whole bytes.
   function automatic logic [2:0] bytes_per_row(input logic [5:0] cols);
      logic [6:0] t;
      t = {1'b0, cols} + 7'd7;
      return t[5:3];
   endfunction

   // Mask with one bit set for every drawn column.
   function automatic logic [31:0] col_mask(input logic [5:0] cols);
      if (cols >= 6'd32) begin
         return '1;
      end
      return (32'd1 << cols[4:0]) - 32'd1;
   endfunction

   // The leftmost pixel sits in the most significant bit of a font byte.
   function automatic logic [7:0] byte_to_mask(input logic [7:0] b);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[i] = b[7 - i];
      end
      return r;
   endfunction

endpackage

// ===== sv/blgr_front.sv =====
// Request front end: classifies requests, resolves the glyph and the cursor.
// Depends on blgr_pkg; feeds blgr_queue.
module blgr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  blgr_pkg::req_type req,
   input  blgr_pkg::cfg_type cfg,
   output logic              push,
   output blgr_pkg::item_type push_item
);
   import blgr_pkg::*;

   logic [CURSOR_W-1:0] cursor_ff;
   logic [CURSOR_W-1:0] cursor_in;
   logic [CURSOR_W-1:0] row_x;
   logic [7:0]          glyph;
   logic                draw_ok;

   // Codes beyond the font fall back to the question mark, or to glyph zero
   // when even that is missing.
   always_comb begin
      if ({5'd0, req.code} >= cfg.glyph_total) begin
         glyph = ({5'd0, FALLBACK_GLYPH} < cfg.glyph_total) ? FALLBACK_GLYPH : 8'd0;
      end else begin
         glyph = req.code;
      end
   end

   assign row_x   = req.start_text ? {1'b0, req.start_x} : cursor_ff;
   assign draw_ok = (req.kind == KIND_DRAW) && cfg.font_ready;

   // Loads always go through; draws are dropped while the font is not ready.
   assign push = accept && ((req.kind == KIND_LOAD) || draw_ok);

   always_comb begin
      push_item.kind      = req.kind;
      push_item.font_addr = req.font_addr;
      push_item.font_byte = req.font_byte;
      push_item.glyph     = glyph;
      push_item.row_x     = row_x;
      push_item.pos_y     = req.pos_y;
      push_item.red       = req.red;
      push_item.green     = req.green;
      push_item.blue      = req.blue;
   end

   always_comb begin
      cursor_in = cursor_ff;
      if (accept && draw_ok) begin
         cursor_in = row_x + CURSOR_W'(eff_cols(cfg.glyph_cols));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else begin
         cursor_ff <= cursor_in;
      end
   end

endmodule

// ===== sv/blgr_queue.sv =====
// Two-entry queue of classified requests between front end and back end.
// Depends on blgr_pkg.
module blgr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  blgr_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output blgr_pkg::item_type head
);
   import blgr_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ff;
   logic       wr_in;
   logic       rd_ff;
   logic       rd_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;

   assign full  = (cnt_ff == 2'd2);
   assign valid = (cnt_ff != 2'd0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ===== sv/blgr_back.sv =====
// Back end: font store, address reduction, row fetch and the result register.
// Depends on blgr_pkg; takes its work from blgr_queue.
module blgr_back #(
   parameter int unsigned FONT_STORE_BYTES = 16384
) (
   input  logic                 clock,
   input  logic                 reset,
   input  blgr_pkg::cfg_type    cfg,
   input  logic                 item_valid,
   input  blgr_pkg::item_type   item,
   output logic                 pop,
   output blgr_pkg::result_type result,
   output logic                 result_valid,
   input  logic                 result_ready
);
   import blgr_pkg::*;

   localparam int unsigned AW      = $clog2(FONT_STORE_BYTES);
   localparam int unsigned RW      = 18;
   localparam int unsigned RED_TOP = (17 > AW) ? 17 - AW : 0;
   localparam int unsigned KW      = $clog2(RED_TOP + 2);
   localparam logic [RW-1:0] STORE_N = RW'(FONT_STORE_BYTES);
   localparam logic [KW-1:0] K_TOP   = KW'(RED_TOP);
   localparam logic [AW:0]   STORE_END = (AW + 1)'(FONT_STORE_BYTES);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RED,
      ST_FETCH,
      ST_WAIT,
      ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   item_type   cur_ff, cur_in;
   logic [RW-1:0] red_ff, red_in;
   logic [KW-1:0] k_ff, k_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [1:0]    j_ff, j_in;
   logic [4:0]    gy_ff, gy_in;
   logic [31:0]   mask_ff, mask_in;
   logic          rd_v_ff, rd_v_in;
   logic [1:0]    rd_lane_ff, rd_lane_in;
   logic [7:0]    rdata_ff;
   result_type    out_ff, out_in;
   logic          out_v_ff, out_v_in;

   logic [7:0]    store_mem [FONT_STORE_BYTES];
   logic          mem_we;
   logic          mem_re;
   logic [RW-1:0] red_sub;
   logic [RW-1:0] red_nx;
   logic [AW:0]   ptr_p1;
   logic [AW-1:0] ptr_next;
   logic [5:0]    cols;
   logic [5:0]    rows;
   logic [2:0]    bpr;
   logic [15:0]   prod;
   logic          out_free;

   assign cols     = eff_cols(cfg.glyph_cols);
   assign rows     = eff_rows(cfg.glyph_rows);
   assign bpr      = bytes_per_row(cols);
   assign prod     = cur_ff.glyph * cfg.glyph_bytes;
   assign red_sub  = STORE_N << k_ff;
   assign red_nx   = (red_ff >= red_sub) ? red_ff - red_sub : red_ff;
   assign ptr_p1   = {1'b0, ptr_ff} + {{AW{1'b0}}, 1'b1};
   assign ptr_next = (ptr_p1 == STORE_END) ? '0 : ptr_p1[AW-1:0];
   assign out_free = !out_v_ff || result_ready;

   assign result       = out_ff;
   assign result_valid = out_v_ff;

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      red_in     = red_ff;
      k_in       = k_ff;
      ptr_in     = ptr_ff;
      j_in       = j_ff;
      gy_in      = gy_ff;
      mask_in    = mask_ff;
      rd_v_in    = 1'b0;
      rd_lane_in = j_ff;
      out_in     = out_ff;
      out_v_in   = out_v_ff && !result_ready;
      pop        = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;

      // Byte lanes arrive in the cycle after their read was issued.
      if (rd_v_ff) begin
         mask_in[{rd_lane_ff, 3'b000} +: 8] = byte_to_mask(rdata_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               pop    = 1'b1;
               cur_in = item;
               k_in   = K_TOP;
               red_in = RW'(item.font_addr);
               state_in = (item.kind == KIND_LOAD) ? ST_RED : ST_MUL;
            end
         end
         ST_MUL: begin
            red_in   = RW'(prod);
            state_in = ST_RED;
         end
         ST_RED: begin
            // One conditional subtract of a shifted store size per cycle.
            red_in = red_nx;
            k_in   = k_ff - {{(KW-1){1'b0}}, 1'b1};
            if (k_ff == '0) begin
               if (cur_ff.kind == KIND_LOAD) begin
                  mem_we   = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  ptr_in  = red_nx[AW-1:0];
                  gy_in   = '0;
                  j_in    = '0;
                  mask_in = '0;
                  if (rows == 6'd0) begin
                     state_in = ST_IDLE;
                  end else if (bpr == 3'd0) begin
                     state_in = ST_EMIT;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            mem_re  = 1'b1;
            rd_v_in = 1'b1;
            ptr_in  = ptr_next;
            j_in    = j_ff + 2'd1;
            if ({1'b0, j_ff} + 3'd1 == bpr) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_in.row_x      = cur_ff.row_x;
               out_in.row_y      = CURSOR_W'(cur_ff.pos_y) + CURSOR_W'(gy_ff);
               out_in.pixel_mask = mask_ff & col_mask(cols);
               out_in.red        = cur_ff.red;
               out_in.green      = cur_ff.green;
               out_in.blue       = cur_ff.blue;
               out_in.last_row   = ({1'b0, gy_ff} + 6'd1 == rows);
               out_v_in          = 1'b1;
               mask_in           = '0;
               gy_in             = gy_ff + 5'd1;
               j_in              = '0;
               if ({1'b0, gy_ff} + 6'd1 == rows) begin
                  state_in = ST_IDLE;
               end else if (bpr == 3'd0) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Font store: one write port for loads, one registered read for rows.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[red_nx[AW-1:0]] <= cur_ff.font_byte;
      end
      if (mem_re) begin
         rdata_ff <= store_mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      red_ff     <= red_in;
      k_ff       <= k_in;
      ptr_ff     <= ptr_in;
      j_ff       <= j_in;
      gy_ff      <= gy_in;
      mask_ff    <= mask_in;
      rd_lane_ff <= rd_lane_in;
      out_ff     <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rd_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_v_ff  <= rd_v_in;
         out_v_ff <= out_v_in;
      end
   end

endmodule

// ===== sv/bitmap_glyph_row_renderer_core.sv =====
// Top level of the bitmap glyph row renderer: ports, configuration registers.
// Depends on blgr_pkg, blgr_front, blgr_queue and blgr_back.
//
// Usage. Requests arrive on the req_ stream. req_tuser selects the kind: a
// load writes one byte into the font store and gives no result; a draw renders
// one character and gives one result per glyph row on the rsp_ stream, a
// 32-bit pixel mask with its x, y and colour, tlast marking the final row.
// The csr_ port sets font_ready, glyph_total, glyph_bytes, glyph_cols and
// glyph_rows; the user writes it only while the block is idle (not enforced).
// Timing. The front end classifies a request in the cycle it is accepted and
// keeps the text cursor, so the next request is taken while the previous one
// is still being drawn, up to two waiting in the queue. The back end reduces
// the store address modulo the store size by conditional subtracts of the store
// size shifted left by R down to zero, where R = 17 - log2(FONT_STORE_BYTES)
// (three for the default 16384 bytes), after a multiply step for a draw. Each
// glyph row then takes bytes_per_row store reads through the single store
// read port, then a wait step and an emit step. Reset clears the cursor,
// the queue and the result valid flag and restores the register defaults;
// the font store keeps no reset value and must be loaded before draws are
// enabled. When the receiver holds rsp_tready low, the row in the result
// register waits and the back end stalls behind it.
module bitmap_glyph_row_renderer_core #(
   parameter int unsigned FONT_STORE_BYTES = 16384
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0 up: font_addr[13:0], font_byte[21:14], code[29:22],
   // start_text[30], start_x[46:31], pos_y[62:47], red_in[70:63],
   // green_in[78:71], blue_in[86:79], zero pad[87].
   input  logic [87:0] req_tdata,
   // kind: 0 = load one font byte, 1 = draw one character.
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0 up: row_x[16:0], row_y[33:17], pixel_mask[65:34],
   // red_out[73:66], green_out[81:74], blue_out[89:82], zero pad[95:90].
   output logic [95:0] rsp_tdata,
   // last_row: set on the final row of a glyph.
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import blgr_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   req_type    req;
   item_type   push_item;
   item_type   head;
   result_type result;
   logic       accept;
   logic       push;
   logic       q_full;
   logic       q_valid;
   logic       pop;

   // Configuration registers; writes beyond the register list are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_FONT_READY:  cfg_in.font_ready  = csr_wdata[0];
            REG_GLYPH_TOTAL: cfg_in.glyph_total = csr_wdata;
            REG_GLYPH_BYTES: cfg_in.glyph_bytes = csr_wdata[7:0];
            REG_GLYPH_COLS:  cfg_in.glyph_cols  = csr_wdata[5:0];
            REG_GLYPH_ROWS:  cfg_in.glyph_rows  = csr_wdata[5:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.font_ready  <= 1'b0;
         cfg_ff.glyph_total <= 13'd256;
         cfg_ff.glyph_bytes <= 8'd16;
         cfg_ff.glyph_cols  <= 6'd8;
         cfg_ff.glyph_rows  <= 6'd16;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Unpack the request fields.
   always_comb begin
      req.kind       = kind_type'(req_tuser);
      req.font_addr  = req_tdata[13:0];
      req.font_byte  = req_tdata[21:14];
      req.code       = req_tdata[29:22];
      req.start_text = req_tdata[30];
      req.start_x    = req_tdata[46:31];
      req.pos_y      = req_tdata[62:47];
      req.red        = req_tdata[70:63];
      req.green      = req_tdata[78:71];
      req.blue       = req_tdata[86:79];
   end

   // A request is taken whenever the queue has room.
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   blgr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req),
      .cfg       (cfg_ff),
      .push      (push),
      .push_item (push_item)
   );

   blgr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .valid     (q_valid),
      .head      (head)
   );

   blgr_back #(
      .FONT_STORE_BYTES (FONT_STORE_BYTES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .item_valid   (q_valid),
      .item         (head),
      .pop          (pop),
      .result       (result),
      .result_valid (rsp_tvalid),
      .result_ready (rsp_tready)
   );

   assign rsp_tdata = {6'd0, result.blue, result.green, result.red,
                       result.pixel_mask, result.row_y, result.row_x};
   assign rsp_tlast = result.last_row;

endmodule
